/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/psp_pkg.sv */
`timescale 1ns / 1ps
package psp_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int LEN_BITS   = SQ_BITS;
    localparam int T_BITS     = SQ_BITS + 2;
    localparam int Q_BITS     = DIFF_BITS;
    localparam int NUM_BITS   = DIFF_BITS + LEN_BITS + 1;
    localparam int RAD_BITS   = 15;
    localparam int THR_BITS   = 2 * (RAD_BITS + 1);
    localparam int DIST_BITS  = 36;
    localparam int MODE_BITS  = 3;
    localparam int SEL_BITS   = 2;

    localparam logic [MODE_BITS-1:0] MODE_PT_CAPSULE  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SPH_SEG     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SPH_CAPSULE = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_SPH_SPH     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PT_SURFACE  = 3'd4;

    localparam logic [SEL_BITS-1:0] SEL_START  = 2'd0;
    localparam logic [SEL_BITS-1:0] SEL_END    = 2'd1;
    localparam logic [SEL_BITS-1:0] SEL_INTERP = 2'd2;

    typedef logic [2:0][COORD_BITS-1:0] t_vec3;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        t_vec3                p;
        t_vec3                s;
        t_vec3                e;
        logic [RAD_BITS-1:0]  ra;
        logic [RAD_BITS-1:0]  rb;
        logic [THR_BITS-1:0]  thr;
        logic [SEL_BITS-1:0]  sel;
        logic [2:0]           dneg;
    } t_ctx;

    typedef struct packed {
        logic valid;
        t_ctx ctx;
    } t_beat;

endpackage

/* rtl/psp_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psp_front import psp_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  t_beat                          i_beat,
    output t_beat                          o_beat,
    output logic [2:0][NUM_BITS-1:0]       o_num,
    output logic [LEN_BITS-1:0]            o_den
);

    // stage a: differences
    logic                        r_a_vld;
    t_ctx                        r_a_ctx;
    logic signed [DIFF_BITS-1:0] r_a_d  [3];
    logic signed [DIFF_BITS-1:0] r_a_sp [3];

    // stage b: products
    logic                        r_b_vld;
    t_ctx                        r_b_ctx;
    logic signed [SQ_BITS-1:0]   r_b_dsp [3];
    logic [SQ_BITS-1:0]          r_b_dd  [3];
    logic [DIFF_BITS-1:0]        r_b_dabs [3];

    // stage c: dot products and classification
    logic                        r_c_vld;
    t_ctx                        r_c_ctx;
    logic [LEN_BITS-1:0]         r_c_t;
    logic [LEN_BITS-1:0]         r_c_len;
    logic [DIFF_BITS-1:0]        r_c_dabs [3];

    // stage d: rounded numerators
    logic                        r_d_vld;
    t_ctx                        r_d_ctx;
    logic [NUM_BITS-1:0]         r_d_num [3];
    logic [LEN_BITS-1:0]         r_d_len;

    logic [THR_BITS-1:0]         n_b_thr;
    t_ctx                        n_b_ctx;
    logic [RAD_BITS:0]           rsum;
    logic signed [T_BITS-1:0]    n_c_t;
    logic [LEN_BITS-1:0]         n_c_len;
    logic [SEL_BITS-1:0]         n_c_sel;
    t_ctx                        n_c_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_beat.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctx <= i_beat.ctx;
            for (int i = 0; i < 3; i++) begin
                r_a_d[i]  <= DIFF_BITS'($signed(i_beat.ctx.e[i]))
                           - DIFF_BITS'($signed(i_beat.ctx.s[i]));
                r_a_sp[i] <= DIFF_BITS'($signed(i_beat.ctx.p[i]))
                           - DIFF_BITS'($signed(i_beat.ctx.s[i]));
            end
        end
    end

    assign rsum = {1'b0, r_a_ctx.ra} + {1'b0, r_a_ctx.rb};

    always_comb begin
        case (r_a_ctx.mode) inside
            MODE_SPH_SEG:                  n_b_thr = THR_BITS'(r_a_ctx.ra * r_a_ctx.ra);
            MODE_SPH_CAPSULE, MODE_SPH_SPH: n_b_thr = THR_BITS'(rsum * rsum);
            default:                       n_b_thr = THR_BITS'(r_a_ctx.rb * r_a_ctx.rb);
        endcase
    end

    always_comb begin
        n_b_ctx     = r_a_ctx;
        n_b_ctx.thr = n_b_thr;
        for (int i = 0; i < 3; i++) begin
            n_b_ctx.dneg[i] = r_a_d[i][DIFF_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_ctx <= n_b_ctx;
            for (int i = 0; i < 3; i++) begin
                r_b_dsp[i]      <= r_a_d[i] * r_a_sp[i];
                r_b_dd[i]       <= $unsigned(SQ_BITS'(r_a_d[i] * r_a_d[i]));
                r_b_dabs[i]     <= r_a_d[i][DIFF_BITS-1] ? $unsigned(-r_a_d[i])
                                                         : $unsigned(r_a_d[i]);
            end
        end
    end

    assign n_c_t = T_BITS'(r_b_dsp[0]) + T_BITS'(r_b_dsp[1]) + T_BITS'(r_b_dsp[2]);
    assign n_c_len = r_b_dd[0] + r_b_dd[1] + r_b_dd[2];

    always_comb begin
        if (r_b_ctx.mode == MODE_SPH_SPH || n_c_len == '0 || n_c_t[T_BITS-1]) begin
            n_c_sel = SEL_START;
        end else if (n_c_t > $signed({2'b00, n_c_len})) begin
            n_c_sel = SEL_END;
        end else begin
            n_c_sel = SEL_INTERP;
        end
    end

    always_comb begin
        n_c_ctx     = r_b_ctx;
        n_c_ctx.sel = n_c_sel;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_ctx     <= n_c_ctx;
            r_c_t       <= n_c_t[LEN_BITS-1:0];
            r_c_len     <= n_c_len;
            r_c_dabs    <= r_b_dabs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ctx <= r_c_ctx;
            r_d_len <= r_c_len;
            for (int i = 0; i < 3; i++) begin
                r_d_num[i] <= NUM_BITS'(r_c_dabs[i]) * NUM_BITS'(r_c_t)
                            + NUM_BITS'(r_c_len >> 1);
            end
        end
    end

    assign o_beat = '{valid: r_d_vld, ctx: r_d_ctx};
    assign o_den  = r_d_len;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_num[i] = r_d_num[i];
        end
    end

    `ASSERT_IMPLIES(a_interp_in_range, i_clk, i_rst_n,
        r_c_vld && r_c_ctx.sel == SEL_INTERP, r_c_t <= r_c_len && r_c_len != '0)

endmodule

/* rtl/psp_div.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psp_div import psp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  t_beat                       i_beat,
    input  logic [2:0][NUM_BITS-1:0]    i_num,
    input  logic [LEN_BITS-1:0]         i_den,
    output t_beat                       o_beat,
    output logic [2:0][Q_BITS-1:0]      o_q
);

    typedef struct packed {
        logic [LEN_BITS-1:0] rem;
        logic [Q_BITS-1:0]   low;
        logic [Q_BITS-1:0]   q;
    } t_lane;

    localparam int LAST = Q_BITS - 1;

    function automatic t_lane div_step(t_lane a, logic [LEN_BITS-1:0] den);
        logic [LEN_BITS:0] trial;
        t_lane             b;
        trial = {a.rem, a.low[Q_BITS-1]};
        b.low = {a.low[Q_BITS-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
            b.rem = LEN_BITS'(trial - {1'b0, den});
            b.q   = {a.q[Q_BITS-2:0], 1'b1};
        end else begin
            b.rem = trial[LEN_BITS-1:0];
            b.q   = {a.q[Q_BITS-2:0], 1'b0};
        end
        return b;
    endfunction

    logic [Q_BITS-1:0]   r_vld;
    t_ctx                r_ctx [Q_BITS];
    logic [LEN_BITS-1:0] r_den [Q_BITS];
    t_lane [2:0]         r_ln  [Q_BITS];
    t_lane [2:0]         init_ln;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            init_ln[i].rem = LEN_BITS'(i_num[i] >> Q_BITS);
            init_ln[i].low = i_num[i][Q_BITS-1:0];
            init_ln[i].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_BITS-2:0], i_beat.valid};
        end
    end

    for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctx[g] <= i_beat.ctx;
                    r_den[g] <= i_den;
                    for (int i = 0; i < 3; i++) begin
                        r_ln[g][i] <= div_step(init_ln[i], i_den);
                    end
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctx[g] <= r_ctx[g-1];
                    r_den[g] <= r_den[g-1];
                    for (int i = 0; i < 3; i++) begin
                        r_ln[g][i] <= div_step(r_ln[g-1][i], r_den[g-1]);
                    end
                end
            end
        end
    end

    assign o_beat = '{valid: r_vld[LAST], ctx: r_ctx[LAST]};
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_q[i] = r_ln[LAST][i].q;
        end
    end

    `ASSERT_IMPLIES(a_init_rem_below_den, i_clk, i_rst_n,
        i_beat.valid && i_beat.ctx.sel == SEL_INTERP,
        init_ln[0].rem < i_den && init_ln[1].rem < i_den && init_ln[2].rem < i_den)
    `ASSERT_IMPLIES(a_final_rem_below_den, i_clk, i_rst_n,
        r_vld[LAST] && r_ctx[LAST].sel == SEL_INTERP,
        r_ln[LAST][0].rem < r_den[LAST] && r_ln[LAST][1].rem < r_den[LAST]
            && r_ln[LAST][2].rem < r_den[LAST])

endmodule

/* rtl/psp_back.sv */
`timescale 1ns / 1ps
module psp_back import psp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_beat                    i_beat,
    input  logic [2:0][Q_BITS-1:0]   i_q,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic [DIST_BITS-1:0]     o_dist_sq,
    output t_vec3                    o_near
);

    logic                    r_e_vld;
    t_ctx                    r_e_ctx;
    t_vec3                   r_e_c;

    logic                    r_f_vld;
    t_ctx                    r_f_ctx;
    t_vec3                   r_f_c;
    logic [SQ_BITS-1:0]      r_f_sq [3];

    logic                    r_o_vld;
    logic                    r_o_hit;
    logic [DIST_BITS-1:0]    r_o_dist;
    t_vec3                   r_o_c;

    t_vec3                   n_e_c;
    logic signed [DIFF_BITS-1:0] df [3];
    logic [DIST_BITS-1:0]    n_dist;
    logic [DIST_BITS-1:0]    thr;
    logic                    n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= i_beat.valid;
            r_f_vld <= r_e_vld;
            r_o_vld <= r_f_vld;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (i_beat.ctx.sel)
                SEL_START: n_e_c[i] = i_beat.ctx.s[i];
                SEL_END:   n_e_c[i] = i_beat.ctx.e[i];
                default: begin
                    if (i_beat.ctx.dneg[i]) begin
                        n_e_c[i] = i_beat.ctx.s[i] - COORD_BITS'(i_q[i]);
                    end else begin
                        n_e_c[i] = i_beat.ctx.s[i] + COORD_BITS'(i_q[i]);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_ctx <= i_beat.ctx;
            r_e_c   <= n_e_c;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            df[i] = DIFF_BITS'($signed(r_e_ctx.p[i])) - DIFF_BITS'($signed(r_e_c[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_ctx <= r_e_ctx;
            r_f_c   <= r_e_c;
            for (int i = 0; i < 3; i++) begin
                r_f_sq[i] <= $unsigned(SQ_BITS'(df[i] * df[i]));
            end
        end
    end

    assign n_dist = DIST_BITS'(r_f_sq[0]) + DIST_BITS'(r_f_sq[1]) + DIST_BITS'(r_f_sq[2]);
    assign thr    = DIST_BITS'(r_f_ctx.thr);

    always_comb begin
        case (r_f_ctx.mode) inside
            MODE_PT_CAPSULE, MODE_SPH_SEG, MODE_SPH_CAPSULE, MODE_SPH_SPH:
                n_hit = n_dist < thr;
            MODE_PT_SURFACE:
                n_hit = n_dist == thr;
            default:
                n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_hit  <= n_hit;
            r_o_dist <= n_dist;
            r_o_c    <= r_f_c;
        end
    end

    assign o_valid   = r_o_vld;
    assign o_hit     = r_o_hit;
    assign o_dist_sq = r_o_dist;
    assign o_near    = r_o_c;

endmodule

/* rtl/point_segment_proximity_test_unit.sv */
`timescale 1ns / 1ps
// channel   handshake             beat
// query     i_valid / o_stall     i_mode, i_point_*, i_seg_start_*, i_seg_end_*, i_radius_*
// result    o_valid / i_stall     o_hit, o_dist_sq, o_near_*
//
// one query accepted per cycle while o_stall is low, one result per query
// the 17-stage restoring divider sits between 4 front and 3 back stages
// synchronous active-low reset clears the valid bits of every stage
// a stalled result freezes the whole pipeline, so o_stall follows o_valid and i_stall
module point_segment_proximity_test_unit import psp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [MODE_BITS-1:0]         i_mode,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_start_z,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_z,
    input  logic [RAD_BITS-1:0]          i_radius_a,
    input  logic [RAD_BITS-1:0]          i_radius_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [DIST_BITS-1:0]         o_dist_sq,
    output logic signed [COORD_BITS-1:0] o_near_x,
    output logic signed [COORD_BITS-1:0] o_near_y,
    output logic signed [COORD_BITS-1:0] o_near_z
);

    logic                      en;
    t_beat                     in_beat;
    t_beat                     fr_beat;
    logic [2:0][NUM_BITS-1:0]  fr_num;
    logic [LEN_BITS-1:0]       fr_den;
    t_beat                     dv_beat;
    logic [2:0][Q_BITS-1:0]    dv_q;
    t_vec3                     near;

    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    always_comb begin
        in_beat           = '0;
        in_beat.valid     = i_valid;
        in_beat.ctx.mode  = i_mode;
        in_beat.ctx.p     = {i_point_z, i_point_y, i_point_x};
        in_beat.ctx.s     = {i_seg_start_z, i_seg_start_y, i_seg_start_x};
        in_beat.ctx.e     = {i_seg_end_z, i_seg_end_y, i_seg_end_x};
        in_beat.ctx.ra    = i_radius_a;
        in_beat.ctx.rb    = i_radius_b;
    end

    psp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_beat  (in_beat),
        .o_beat  (fr_beat),
        .o_num   (fr_num),
        .o_den   (fr_den)
    );

    psp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_beat  (fr_beat),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .o_beat  (dv_beat),
        .o_q     (dv_q)
    );

    psp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_beat    (dv_beat),
        .i_q       (dv_q),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_dist_sq (o_dist_sq),
        .o_near    (near)
    );

    assign o_near_x = near[0];
    assign o_near_y = near[1];
    assign o_near_z = near[2];

endmodule

/* verif/tb_point_segment_proximity_test_unit.sv */
`timescale 1ns / 1ps
module tb_point_segment_proximity_test_unit;
    import psp_pkg::*;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        t_vec3                pt;
        t_vec3                st;
        t_vec3                en;
        logic [RAD_BITS-1:0]  ra;
        logic [RAD_BITS-1:0]  rb;
    } t_query;

    typedef struct packed {
        logic                 hit;
        logic [DIST_BITS-1:0] dist_sq;
        t_vec3                near;
    } t_verdict;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [MODE_BITS-1:0]         i_mode = '0;
    logic signed [COORD_BITS-1:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [COORD_BITS-1:0] i_seg_start_x = '0, i_seg_start_y = '0, i_seg_start_z = '0;
    logic signed [COORD_BITS-1:0] i_seg_end_x = '0, i_seg_end_y = '0, i_seg_end_z = '0;
    logic [RAD_BITS-1:0]          i_radius_a = '0, i_radius_b = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic                         o_hit;
    logic [DIST_BITS-1:0]         o_dist_sq;
    logic signed [COORD_BITS-1:0] o_near_x, o_near_y, o_near_z;

    t_query   pending_queries[$];
    t_verdict expected_verdicts[$];
    t_query   cur_query;
    int       n_total = 0;
    int       n_accepted = 0;
    int       n_checked = 0;
    int       n_hits = 0;
    int       n_errors = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    logic     hold_off = 1'b0;

    point_segment_proximity_test_unit u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit [63:0] sx(logic [COORD_BITS-1:0] v);
        return {{(64-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // closest point, squared distance and verdict, all modulo 2^64
    function automatic t_verdict predict_proximity(t_query q);
        bit [63:0] p[3], s[3], e[3], d[3], c[3];
        bit [63:0] t, len2, dsum, rsum, ra, rb, mag, quo, df;
        bit        hit;
        t_verdict  v;
        t = 0;
        len2 = 0;
        dsum = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = sx(q.pt[i]);
            s[i] = sx(q.st[i]);
            e[i] = sx(q.en[i]);
            d[i] = e[i] - s[i];
            t += d[i] * (p[i] - s[i]);
            len2 += d[i] * d[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (q.mode == MODE_SPH_SPH || len2 == 0 || t[63]) begin
                c[i] = s[i];
            end else if (t > len2) begin
                c[i] = e[i];
            end else begin
                mag = d[i][63] ? (64'd0 - d[i]) : d[i];
                quo = (mag * t + (len2 >> 1)) / len2;
                c[i] = d[i][63] ? (s[i] - quo) : (s[i] + quo);
            end
            df = p[i] - c[i];
            dsum += df * df;
            v.near[i] = c[i][COORD_BITS-1:0];
        end
        ra = 64'(q.ra);
        rb = 64'(q.rb);
        rsum = ra + rb;
        case (q.mode)
            MODE_PT_CAPSULE:  hit = dsum < rb * rb;
            MODE_SPH_SEG:     hit = dsum < ra * ra;
            MODE_SPH_CAPSULE: hit = dsum < rsum * rsum;
            MODE_SPH_SPH:     hit = dsum < rsum * rsum;
            MODE_PT_SURFACE:  hit = dsum == rb * rb;
            default:          hit = 1'b0;
        endcase
        v.hit = hit;
        v.dist_sq = dsum[DIST_BITS-1:0];
        return v;
    endfunction

    function automatic t_vec3 vec(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic t_query mk(logic [MODE_BITS-1:0] m, t_vec3 p, t_vec3 s, t_vec3 e,
                                  int ra, int rb);
        t_query q;
        q.mode = m;
        q.pt = p;
        q.st = s;
        q.en = e;
        q.ra = 15'(ra);
        q.rb = 15'(rb);
        return q;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic t_vec3 near_vec(t_vec3 base, int spread);
        t_vec3 v;
        for (int i = 0; i < 3; i++)
            v[i] = base[i] + 16'(int'($urandom_range(0, 2 * spread)) - spread);
        return v;
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int     kind;
        int     r;
        t_vec3  base;
        kind = $urandom_range(0, 99);
        q.mode = (($urandom_range(0, 9)) == 0) ? MODE_BITS'($urandom_range(5, 7))
                                              : MODE_BITS'($urandom_range(0, 4));
        if (kind < 35) begin
            q.pt = vec(rand_coord(), rand_coord(), rand_coord());
            q.st = vec(rand_coord(), rand_coord(), rand_coord());
            q.en = vec(rand_coord(), rand_coord(), rand_coord());
            q.ra = 15'($urandom);
            q.rb = 15'($urandom);
        end else if (kind < 80) begin
            base = vec(rand_coord() / 2, rand_coord() / 2, rand_coord() / 2);
            r = 1 << $urandom_range(2, 13);
            q.st = near_vec(base, r);
            q.en = near_vec(base, r);
            q.pt = near_vec(base, r);
            q.ra = 15'($urandom_range(0, r));
            q.rb = 15'($urandom_range(0, r));
        end else if (kind < 90) begin
            q.st = vec(rand_coord(), rand_coord(), rand_coord());
            q.en = q.st;
            q.pt = near_vec(q.st, 1 << $urandom_range(1, 12));
            q.ra = 15'($urandom_range(0, 4096));
            q.rb = 15'($urandom_range(0, 4096));
        end else begin
            // point placed one radius, give or take one unit, from a degenerate segment
            r = $urandom_range(0, 16000);
            q.mode = MODE_PT_SURFACE;
            q.st = vec(rand_coord() / 2, rand_coord() / 2, rand_coord() / 2);
            q.en = q.st;
            q.pt = q.st;
            q.pt[$urandom_range(0, 2)] += 16'($urandom_range(0, 1) ? r : -r);
            q.ra = 15'($urandom);
            q.rb = 15'(r + int'($urandom_range(0, 2)) - 1);
        end
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        if ((n_accepted / 200) % 4 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // query driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_verdicts.push_back(predict_proximity(cur_query));
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_queries.size() > 0) begin
                    cur_query = pending_queries.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= cur_query.mode;
                    i_point_x <= cur_query.pt[0];
                    i_point_y <= cur_query.pt[1];
                    i_point_z <= cur_query.pt[2];
                    i_seg_start_x <= cur_query.st[0];
                    i_seg_start_y <= cur_query.st[1];
                    i_seg_start_z <= cur_query.st[2];
                    i_seg_end_x <= cur_query.en[0];
                    i_seg_end_y <= cur_query.en[1];
                    i_seg_end_z <= cur_query.en[2];
                    i_radius_a <= cur_query.ra;
                    i_radius_b <= cur_query.rb;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("unexpected result beat: hit=%0b dist_sq=%0h", o_hit, o_dist_sq);
                end else begin
                    want = expected_verdicts.pop_front();
                    n_checked <= n_checked + 1;
                    n_hits <= n_hits + int'(o_hit);
                    if (o_hit !== want.hit || o_dist_sq !== want.dist_sq ||
                        o_near_x !== want.near[0] || o_near_y !== want.near[1] ||
                        o_near_z !== want.near[2]) begin
                        n_errors <= n_errors + 1;
                        if (n_errors < 10)
                            $display("result %0d mismatch: exp hit=%0b d=%0h n=%0h/%0h/%0h got hit=%0b d=%0h n=%0h/%0h/%0h",
                                     n_checked, want.hit, want.dist_sq, want.near[0],
                                     want.near[1], want.near[2], o_hit, o_dist_sq,
                                     o_near_x, o_near_y, o_near_z);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else if (hold_off) begin
                i_stall <= 1'b1;
            end else begin
                stall_left <= pick_gap();
                i_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial begin
        wait (n_accepted >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("tb_point_segment_proximity_test_unit: done, errors");
        $finish;
    end

    initial begin
        for (int m = 0; m < 8; m++)
            pending_queries.push_back(mk(MODE_BITS'(m), vec(300, -200, 50), vec(0, 0, 0),
                                         vec(1000, 0, 0), 260, 400));
        pending_queries.push_back(mk(MODE_PT_CAPSULE, vec(0, 0, 0), vec(0, 0, 0),
                                     vec(0, 0, 0), 0, 0));
        pending_queries.push_back(mk(MODE_SPH_CAPSULE, vec(32767, 32767, 32767),
                                     vec(-32768, -32768, -32768), vec(32767, -32768, 32767),
                                     32767, 32767));
        pending_queries.push_back(mk(MODE_SPH_SEG, vec(-32768, -32768, -32768),
                                     vec(32767, 32767, 32767), vec(-32768, 32767, -32768),
                                     32767, 0));
        pending_queries.push_back(mk(MODE_PT_CAPSULE, vec(-500, 10, 0), vec(0, 0, 0),
                                     vec(100, 0, 0), 0, 600));
        pending_queries.push_back(mk(MODE_PT_CAPSULE, vec(900, 10, 0), vec(0, 0, 0),
                                     vec(100, 0, 0), 0, 900));
        pending_queries.push_back(mk(MODE_PT_CAPSULE, vec(1, 0, 0), vec(0, 0, 0),
                                     vec(1, 1, 0), 0, 1));
        pending_queries.push_back(mk(MODE_PT_CAPSULE, vec(-1, 0, 0), vec(0, 0, 0),
                                     vec(-1, -1, 0), 0, 1));
        pending_queries.push_back(mk(MODE_PT_SURFACE, vec(1300, 0, 0), vec(1000, 0, 0),
                                     vec(1000, 0, 0), 5, 300));
        pending_queries.push_back(mk(MODE_PT_SURFACE, vec(5, 7, 300), vec(5, 7, 0),
                                     vec(5, 7, 0), 32767, 299));
        pending_queries.push_back(mk(MODE_SPH_SPH, vec(100, 0, 0), vec(0, 0, 0),
                                     vec(50, 0, 0), 50, 50));
        pending_queries.push_back(mk(MODE_SPH_SPH, vec(99, 0, 0), vec(0, 0, 0),
                                     vec(-32768, 32767, 0), 50, 50));
        pending_queries.push_back(mk(MODE_PT_CAPSULE, vec(7, -3, 12), vec(-20, 4, 9),
                                     vec(-20, 4, 9), 3, 28));
        pending_queries.push_back(mk(3'd7, vec(-32768, 0, 32767), vec(32767, 0, -32768),
                                     vec(0, 32767, 0), 16384, 21845));
        for (int i = 0; i < 1200; i++)
            pending_queries.push_back(rand_query());
        n_total = pending_queries.size();
        wait (i_rst_n);
        wait (n_accepted == n_total);
        wait (expected_verdicts.size() == 0);
        repeat (60) @(posedge i_clk);
        if (expected_verdicts.size() != 0)
            n_errors = n_errors + expected_verdicts.size();
        $display("checked %0d results over all eight mode codes (%0d hits), incl. degenerate,",
                 n_checked, n_hits);
        $display("clamped, rounding-tie and exact-surface queries under random gaps and stalls");
        if (n_errors == 0 && n_checked == n_total) begin
            $display("tb_point_segment_proximity_test_unit: done, clean");
        end else begin
            $display("tb_point_segment_proximity_test_unit: done, errors");
        end
        $finish;
    end

endmodule
